// ===== rtl/lil_pkg.sv =====
package lil_pkg;

    localparam int unsigned ENTRIES_DEF = 1024;
    localparam int unsigned IDX_W       = 10;
    localparam int unsigned STEP_W      = 3;

    localparam logic [1:0] OP_TOUCH  = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [STEP_W-1:0] ST_WIPE   = 3'd0;
    localparam logic [STEP_W-1:0] ST_IDLE   = 3'd1;
    localparam logic [STEP_W-1:0] ST_READ   = 3'd2;
    localparam logic [STEP_W-1:0] ST_UNLINK = 3'd3;
    localparam logic [STEP_W-1:0] ST_CLEAR  = 3'd4;
    localparam logic [STEP_W-1:0] ST_APPEND = 3'd5;
    localparam logic [STEP_W-1:0] ST_FINISH = 3'd6;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [IDX_W-1:0] entry_index;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] popped_index;
        logic             status;
        logic             list_empty;
    } t_out_item;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_WIPE,
        ACT_READ,
        ACT_UNLINK,
        ACT_CLEAR,
        ACT_APPEND,
        ACT_DONE
    } t_act;

    typedef enum logic [2:0] {
        C_NEXT,
        C_GOTO,
        C_WIPE,
        C_DISPATCH,
        C_TOUCH,
        C_OUT
    } t_cond;

    typedef struct packed {
        t_act              act;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    function automatic t_uword f_ucode(input logic [STEP_W-1:0] addr);
        t_uword w;
        case (addr)
            ST_WIPE:   w = '{act: ACT_WIPE,   cond: C_WIPE,     target: ST_IDLE};
            ST_IDLE:   w = '{act: ACT_NONE,   cond: C_DISPATCH, target: ST_READ};
            ST_READ:   w = '{act: ACT_READ,   cond: C_NEXT,     target: ST_UNLINK};
            ST_UNLINK: w = '{act: ACT_UNLINK, cond: C_NEXT,     target: ST_CLEAR};
            ST_CLEAR:  w = '{act: ACT_CLEAR,  cond: C_TOUCH,    target: ST_FINISH};
            ST_APPEND: w = '{act: ACT_APPEND, cond: C_NEXT,     target: ST_FINISH};
            ST_FINISH: w = '{act: ACT_DONE,   cond: C_OUT,      target: ST_IDLE};
            default:   w = '{act: ACT_NONE,   cond: C_GOTO,     target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/lru_index_list_top.sv =====
// LRU order over entry indices, kept as a doubly linked list in two link memories.
// Input channel: i_in_valid / o_in_stall carry one transaction of opcode (touch,
// pop, remove) and entry index. Output channel: o_out_valid / i_out_stall carry
// one result transaction per input: popped index, status and list-empty flag.
// A short microprogram in a read-only table steps a single datapath; the one
// read port and one write port of each link memory set the number of steps.
// A touch that moves or inserts an entry steps through read, unlink, clear,
// append and finish; a pop or a remove skips append; an ignored request goes to finish.
// The result sits in an output register in the cycle after the last step.
// After reset the link memories are wiped to null, one entry per cycle, over
// all ENTRIES entries; o_in_stall is high throughout that pass.
// A stalled result holds in the output register; the block may then accept and
// work on the next transaction, but waits in its final step until the output
// register is free.
module lru_index_list_top #(
    parameter int unsigned ENTRIES = lil_pkg::ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lil_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output lil_pkg::t_out_item o_out_data
);

    localparam int unsigned LW = $clog2(ENTRIES + 1);
    localparam int unsigned AW = $clog2(ENTRIES);
    localparam logic [LW-1:0] L_NULL = LW'(ENTRIES);
    localparam logic [AW-1:0] WIPE_LAST = AW'(ENTRIES - 1);

    logic [LW-1:0] prev_mem [ENTRIES];
    logic [LW-1:0] next_mem [ENTRIES];

    logic [lil_pkg::STEP_W-1:0] r_step;
    logic [lil_pkg::STEP_W-1:0] n_step;
    logic [AW-1:0]              r_wipe;
    logic [LW-1:0]              r_head;
    logic [LW-1:0]              r_tail;
    logic [LW-1:0]              r_idx;
    logic [1:0]                 r_op;
    logic [lil_pkg::IDX_W-1:0]  r_popped;
    logic                       r_status;
    logic [LW-1:0]              r_rd_prev;
    logic [LW-1:0]              r_rd_next;
    logic                       r_out_valid;
    lil_pkg::t_out_item         r_out;

    lil_pkg::t_uword u;
    logic            in_accept;
    logic            out_free;
    logic            head_ok;
    logic            tail_ok;
    logic            p_ok;
    logic            n_ok;
    logic            listed;
    logic            idx_ok;
    logic [LW-1:0]   idx_ext;
    logic            go;

    logic            prev_we;
    logic [AW-1:0]   prev_addr;
    logic [LW-1:0]   prev_wdata;
    logic            next_we;
    logic [AW-1:0]   next_addr;
    logic [LW-1:0]   next_wdata;

    assign u          = lil_pkg::f_ucode(r_step);
    assign o_in_stall = (r_step != lil_pkg::ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign head_ok    = (32'(r_head) < ENTRIES);
    assign tail_ok    = (32'(r_tail) < ENTRIES);
    assign p_ok       = (32'(r_rd_prev) < ENTRIES);
    assign n_ok       = (32'(r_rd_next) < ENTRIES);
    assign listed     = p_ok || n_ok || (r_head == r_idx);
    assign idx_ok     = (32'(i_in_data.entry_index) < ENTRIES);
    assign idx_ext    = LW'(i_in_data.entry_index);

    always_comb begin
        case (i_in_data.opcode)
            lil_pkg::OP_TOUCH:  go = idx_ok && (r_tail != idx_ext);
            lil_pkg::OP_POP:    go = head_ok;
            lil_pkg::OP_REMOVE: go = idx_ok;
            default:            go = 1'b0;
        endcase
    end

    always_comb begin
        case (u.cond)
            lil_pkg::C_NEXT:     n_step = r_step + 1'b1;
            lil_pkg::C_GOTO:     n_step = u.target;
            lil_pkg::C_WIPE:     n_step = (r_wipe == WIPE_LAST) ? u.target : r_step;
            lil_pkg::C_DISPATCH: begin
                if (!in_accept) begin
                    n_step = r_step;
                end else if (go) begin
                    n_step = u.target;
                end else begin
                    n_step = lil_pkg::ST_FINISH;
                end
            end
            lil_pkg::C_TOUCH:    n_step = (r_op == lil_pkg::OP_TOUCH) ? r_step + 1'b1 : u.target;
            lil_pkg::C_OUT:      n_step = out_free ? u.target : r_step;
            default:             n_step = lil_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        prev_we    = 1'b0;
        prev_addr  = r_idx[AW-1:0];
        prev_wdata = L_NULL;
        next_we    = 1'b0;
        next_addr  = r_idx[AW-1:0];
        next_wdata = L_NULL;
        case (u.act)
            lil_pkg::ACT_WIPE: begin
                prev_we   = 1'b1;
                prev_addr = r_wipe;
                next_we   = 1'b1;
                next_addr = r_wipe;
            end
            lil_pkg::ACT_UNLINK: begin
                if (listed) begin
                    prev_we    = n_ok;
                    prev_addr  = r_rd_next[AW-1:0];
                    prev_wdata = r_rd_prev;
                    next_we    = p_ok;
                    next_addr  = r_rd_prev[AW-1:0];
                    next_wdata = r_rd_next;
                end
            end
            lil_pkg::ACT_CLEAR: begin
                prev_we = 1'b1;
                next_we = 1'b1;
            end
            lil_pkg::ACT_APPEND: begin
                prev_we    = 1'b1;
                prev_wdata = r_tail;
                next_we    = tail_ok;
                next_addr  = r_tail[AW-1:0];
                next_wdata = r_idx;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            prev_mem[prev_addr] <= prev_wdata;
        end
        if (u.act == lil_pkg::ACT_READ) begin
            r_rd_prev <= prev_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            next_mem[next_addr] <= next_wdata;
        end
        if (u.act == lil_pkg::ACT_READ) begin
            r_rd_next <= next_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= lil_pkg::ST_WIPE;
            r_wipe      <= '0;
            r_head      <= L_NULL;
            r_tail      <= L_NULL;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (u.act == lil_pkg::ACT_WIPE) begin
                r_wipe <= r_wipe + 1'b1;
            end
            if ((u.act == lil_pkg::ACT_UNLINK) && listed) begin
                if (!p_ok) begin
                    r_head <= r_rd_next;
                end
                if (!n_ok) begin
                    r_tail <= r_rd_prev;
                end
            end
            if (u.act == lil_pkg::ACT_APPEND) begin
                r_tail <= r_idx;
                if (!head_ok) begin
                    r_head <= r_idx;
                end
            end
            if ((u.act == lil_pkg::ACT_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op <= i_in_data.opcode;
            if (i_in_data.opcode == lil_pkg::OP_POP) begin
                r_idx    <= r_head;
                r_popped <= head_ok ? lil_pkg::IDX_W'(r_head) : '0;
                r_status <= !head_ok;
            end else begin
                r_idx    <= idx_ext;
                r_popped <= '0;
                r_status <= 1'b0;
            end
        end
        if ((u.act == lil_pkg::ACT_DONE) && out_free) begin
            r_out.popped_index <= r_popped;
            r_out.status       <= r_status;
            r_out.list_empty   <= !head_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
